@@ sv/bau_pkg.sv @@
// Shared types and constants for the bilinear alpha upscaler.
// No dependencies; every other file imports this package.
package bau_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_FACTOR = 8;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

	localparam int DIM_W  = 9;
	localparam int FAC_W  = 4;
	localparam int CRD_W  = 11;
	localparam int PIX_W  = 8;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 9;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 8;

	// divider: 16-bit dividend, 9-bit divisor
	localparam int DIV_W  = 16;
	localparam int DVS_W  = 9;
	localparam int DCNT_W = $clog2(DIV_W);

	typedef enum logic [IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_SCALE_FACTOR  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		DSEL_X = 2'd0,
		DSEL_Y = 2'd1,
		DSEL_V = 2'd2
	} dsel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVX,
		ST_WAITX,
		ST_DIVY,
		ST_WAITY,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RDW,
		ST_BL1,
		ST_BL2,
		ST_DIVV,
		ST_WAITV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       take;
		logic       cap_chk;
		logic       div_start;
		dsel_t      div_sel;
		logic       cap_x;
		logic       cap_y;
		logic       rd_en;
		logic [1:0] rd_idx;
		logic       blend_a;
		logic       blend_b;
		logic       cap_v;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic oor;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

@@ sv/bilinear_alpha_upscaler.sv @@
// Top level of the bilinear alpha upscaler: controller plus datapath.
// Depends on bau_pkg, bau_ctrl, bau_datapath (and bau_div below it).
//
// channel  direction  handshake              payload
// s_*      in         s_tvalid / s_tready    tdata: coord_x, coord_y, pixel_in; tuser: operation
// m_*      out        m_tvalid / m_tready    tdata: pixel_out; tuser: out_of_range
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request runs the range check, the column and row passes of the shared bit-serial divider,
// four store reads plus a drain state, two blend steps, the normalization pass and the output
// load; an out-of-range request goes from the range check to the output load. No new item is
// accepted until a request has handed off its result.
// Reset clears control state and sets config to its defaults; the frame store is not cleared.
// A stalled result waits in the output register; the next result holds the input.
module bilinear_alpha_upscaler import bau_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // coord_x[10:0], coord_y[21:11], pixel_in[29:22]
	input  logic                s_tuser,   // operation[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // pixel_out[7:0]
	output logic                m_tuser,   // out_of_range[0]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	bau_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

@@ sv/bau_div.sv @@
// Restoring divider, one quotient bit per cycle, for the upscaler datapath.
// Depends on bau_pkg for widths.
module bau_div import bau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic [DIV_W-1:0]  acc_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;
	logic              last;

	assign trial = {rem_q, acc_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign last  = (cnt_q == DCNT_W'(DIV_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// shift the quotient bit in where the dividend bit left
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			acc_q <= {acc_q[DIV_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

@@ sv/bau_datapath.sv @@
// Datapath of the upscaler: config registers, frame store, axis sampling,
// blend arithmetic and output register. Depends on bau_pkg and bau_div.
module bau_datapath import bau_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic                cfg_valid,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);

	logic [DIM_W-1:0] src_w_q;
	logic [DIM_W-1:0] src_h_q;
	logic [FAC_W-1:0] fac_q;

	logic [DIM_W-1:0] w_sat;
	logic [DIM_W-1:0] h_sat;
	logic [FAC_W-1:0] f_sat;
	logic [4:0]       d;
	logic [7:0]       f_sq;
	logic [DVS_W-1:0] dsq;
	logic [12:0]      wf;
	logic [12:0]      hf;

	logic [CRD_W-1:0] in_x;
	logic [CRD_W-1:0] in_y;
	logic [PIX_W-1:0] in_pix;
	logic [CRD_W-1:0] cx_q;
	logic [CRD_W-1:0] cy_q;
	logic             oor_q;

	logic [CRD_W:0]   numx;
	logic [CRD_W:0]   numy;
	logic [CRD_W:0]   divx;
	logic [CRD_W:0]   divy;

	logic             div_busy;
	logic             div_done;
	logic [DIV_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic [DIV_W-1:0] quot;
	logic [DVS_W-1:0] rem;

	logic [COL_W-1:0] x0_q;
	logic [COL_W-1:0] x1_q;
	logic [ROW_W-1:0] y0_q;
	logic [ROW_W-1:0] y1_q;
	logic [3:0]       kx_q;
	logic [3:0]       ky_q;
	logic [2*COL_W-1:0] xpair;
	logic [2*ROW_W-1:0] ypair;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] mem_q;
	logic             we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic             rd_en_s1;
	logic [1:0]       rd_idx_s1;
	logic [PIX_W-1:0] pix_q [4];

	logic [4:0]       wx0;
	logic [4:0]       wy0;
	logic [12:0]      top_n;
	logic [12:0]      bot_n;
	logic [11:0]      top_q;
	logic [11:0]      bot_q;
	logic [16:0]      num_n;
	logic [DIV_W-1:0] num_q;
	logic [PIX_W-1:0] v_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic                m_tuser_q;

	// lo neighbor clamped to n-1, hi neighbor one further unless past the edge
	function automatic logic [15:0] clamp_pair(logic [DIV_W-1:0] q, logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] nm1;
		logic [7:0]       lo;
		logic [7:0]       hi;
		logic [DIM_W-1:0] lo_p1;
		nm1   = n - 1'b1;
		lo    = (q > {7'b0, nm1}) ? nm1[7:0] : q[7:0];
		lo_p1 = {1'b0, lo} + 1'b1;
		hi    = (lo_p1 < n) ? lo_p1[7:0] : nm1[7:0];
		return {hi, lo};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(256);
			src_h_q <= DIM_W'(256);
			fac_q   <= FAC_W'(2);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_SCALE_FACTOR:  fac_q   <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_w_q == '0) w_sat = DIM_W'(1);
		else if (src_w_q > DIM_W'(MAX_WIDTH)) w_sat = DIM_W'(MAX_WIDTH);
		else w_sat = src_w_q;
		if (src_h_q == '0) h_sat = DIM_W'(1);
		else if (src_h_q > DIM_W'(MAX_HEIGHT)) h_sat = DIM_W'(MAX_HEIGHT);
		else h_sat = src_h_q;
		if (fac_q < FAC_W'(2)) f_sat = FAC_W'(2);
		else if (fac_q > FAC_W'(MAX_FACTOR)) f_sat = FAC_W'(MAX_FACTOR);
		else f_sat = fac_q;
	end

	assign d    = {f_sat, 1'b0};
	assign f_sq = {4'b0, f_sat} * {4'b0, f_sat};
	assign dsq  = {f_sq[6:0], 2'b00};
	assign wf   = {4'b0, w_sat} * {9'b0, f_sat};
	assign hf   = {4'b0, h_sat} * {9'b0, f_sat};

	assign in_x   = s_tdata[CRD_W-1:0];
	assign in_y   = s_tdata[2*CRD_W-1:CRD_W];
	assign in_pix = s_tdata[2*CRD_W+PIX_W-1:2*CRD_W];

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cx_q <= in_x;
			cy_q <= in_y;
		end
		if (cmd.cap_chk) begin
			oor_q <= sts.oor;
		end
	end

	// sample position 2p+1-f, floored at zero before the divide by 2f
	assign numx = {cx_q, 1'b1};
	assign numy = {cy_q, 1'b1};
	assign divx = (numx >= {8'b0, f_sat}) ? numx - {8'b0, f_sat} : '0;
	assign divy = (numy >= {8'b0, f_sat}) ? numy - {8'b0, f_sat} : '0;

	always_comb begin
		case (cmd.div_sel)
			DSEL_X: begin
				dvd = {4'b0, divx};
				dvs = {4'b0, d};
			end
			DSEL_Y: begin
				dvd = {4'b0, divy};
				dvs = {4'b0, d};
			end
			DSEL_V: begin
				dvd = num_q;
				dvs = dsq;
			end
			default: begin
				dvd = '0;
				dvs = {4'b0, d};
			end
		endcase
	end

	bau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (quot),
		.remainder (rem)
	);

	assign xpair = clamp_pair(quot, w_sat);
	assign ypair = clamp_pair(quot, h_sat);

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			x0_q <= xpair[COL_W-1:0];
			x1_q <= xpair[2*COL_W-1:COL_W];
			kx_q <= rem[3:0];
		end
		if (cmd.cap_y) begin
			y0_q <= ypair[ROW_W-1:0];
			y1_q <= ypair[2*ROW_W-1:ROW_W];
			ky_q <= rem[3:0];
		end
	end

	// frame store: one write port for loads, one registered read port
	assign we    = cmd.take && (op_t'(s_tuser) == OP_LOAD)
		&& (in_x < {2'b0, w_sat}) && (in_y < {2'b0, h_sat});
	assign waddr = {in_y[ROW_W-1:0], in_x[COL_W-1:0]};

	always_comb begin
		case (cmd.rd_idx)
			2'd0:    raddr = {y0_q, x0_q};
			2'd1:    raddr = {y0_q, x1_q};
			2'd2:    raddr = {y1_q, x0_q};
			2'd3:    raddr = {y1_q, x1_q};
			default: raddr = {y0_q, x0_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= in_pix;
		end
		if (cmd.rd_en) begin
			mem_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.rd_idx;
		if (rd_en_s1) begin
			pix_q[rd_idx_s1] <= mem_q;
		end
	end

	// horizontal blend of both rows, then vertical blend plus rounding offset
	assign wx0   = d - {1'b0, kx_q};
	assign wy0   = d - {1'b0, ky_q};
	assign top_n = {5'b0, pix_q[0]} * {8'b0, wx0} + {5'b0, pix_q[1]} * {9'b0, kx_q};
	assign bot_n = {5'b0, pix_q[2]} * {8'b0, wx0} + {5'b0, pix_q[3]} * {9'b0, kx_q};
	assign num_n = {5'b0, top_q} * {12'b0, wy0} + {5'b0, bot_q} * {13'b0, ky_q}
		+ {8'b0, f_sq[6:0], 2'b00} / 17'd2;

	always_ff @(posedge clk) begin
		if (cmd.blend_a) begin
			top_q <= top_n[11:0];
			bot_q <= bot_n[11:0];
		end
		if (cmd.blend_b) begin
			num_q <= num_n[DIV_W-1:0];
		end
		if (cmd.cap_v) begin
			v_q <= (|quot[DIV_W-1:PIX_W]) ? {PIX_W{1'b1}} : quot[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= oor_q ? '0 : v_q;
			m_tuser_q <= oor_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign sts.oor      = ({2'b0, cx_q} >= wf) || ({2'b0, cy_q} >= hf);
	assign sts.div_done = div_done;
	assign sts.out_busy = m_tvalid_q && !m_tready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded while previous item still waits");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("out-of-range item carries nonzero data");

	a_read_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !cmd.take)
		else $error("frame store read while an input item is taken");

endmodule

@@ sv/bau_ctrl.sv @@
// Controller state machine of the upscaler: sequences checks, divides,
// frame store reads, blend steps and the result hand-off. Depends on bau_pkg.
module bau_ctrl import bau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tuser,
	input  sts_t sts,
	output cmd_t cmd,
	output logic s_tready
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (op_t'(s_tuser) == OP_REQUEST)) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = sts.oor ? ST_OUT : ST_DIVX;
			ST_DIVX:  state_d = ST_WAITX;
			ST_WAITX: begin
				if (sts.div_done) state_d = ST_DIVY;
			end
			ST_DIVY:  state_d = ST_WAITY;
			ST_WAITY: begin
				if (sts.div_done) state_d = ST_RD0;
			end
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = ST_RDW;
			ST_RDW:   state_d = ST_BL1;
			ST_BL1:   state_d = ST_BL2;
			ST_BL2:   state_d = ST_DIVV;
			ST_DIVV:  state_d = ST_WAITV;
			ST_WAITV: begin
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_CHECK: cmd.cap_chk = 1'b1;
			ST_DIVX: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_X;
			end
			ST_WAITX: begin
				cmd.div_sel = DSEL_X;
				cmd.cap_x   = sts.div_done;
			end
			ST_DIVY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_Y;
			end
			ST_WAITY: begin
				cmd.div_sel = DSEL_Y;
				cmd.cap_y   = sts.div_done;
			end
			ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = 2'd0;
			end
			ST_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = 2'd1;
			end
			ST_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = 2'd2;
			end
			ST_RD3: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = 2'd3;
			end
			ST_RDW: ;
			ST_BL1: cmd.blend_a = 1'b1;
			ST_BL2: cmd.blend_b = 1'b1;
			ST_DIVV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_V;
			end
			ST_WAITV: begin
				cmd.div_sel = DSEL_V;
				cmd.cap_v   = sts.div_done;
			end
			ST_OUT: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule
